// File: rtl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern search block.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // fixed storage of the pattern registers
  localparam int unsigned PAT_BYTES  = 16;
  localparam int unsigned PAT_IDX_W  = 4;
  localparam int unsigned PAT_LEN_W  = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  // a pattern byte of this value matches any image byte
  localparam logic [7:0] WILDCARD = 8'h00;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2
  } cfg_reg_e;

  typedef logic [PAT_BYTES-1:0][7:0] pattern_t;

  // pattern as seen by the compare, length already clamped to 1..max
  typedef struct packed {
    pattern_t               pattern;
    logic [PAT_LEN_W-1:0]   length;
  } cfg_t;

endpackage

// File: rtl/wildcard_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search
// Streams an image byte by byte and reports the first wildcard pattern match.
// ----------------------------------------------------------------------------
// The block takes one image byte per cycle with no gaps of its own: a byte is
// shifted into the window on the transfer and compared in the next cycle, and
// the result of an image is registered once its last byte leaves the compare
// stage. One result (found flag, start offset of the first match) is given per
// image; the bytes of the next image keep flowing while it waits, and only a
// further last byte stalls while an earlier result has not been taken.
// Pattern bytes of zero match anything; the length is clamped to 1 .. max.
module wildcard_byte_pattern_search #(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned OFFSET_BITS       = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // image bytes
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        data_byte_i,
  input  logic                              last_byte_i,
  // result
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              found_o,
  output logic [OFFSET_BITS-1:0]            match_offset_o
);
  import wbps_pkg::*;

  localparam int unsigned CNT_W = OFFSET_BITS + 1;

  cfg_t                              cfg;
  logic [MAX_PATTERN_BYTES-1:0][7:0] window;
  logic [CNT_W-1:0]                  count;
  logic [CNT_W-1:0]                  start;
  logic                              hit;

  logic                   s1_valid_q, s1_last_q;
  logic                   latched_q;
  logic [OFFSET_BITS-1:0] first_q;
  logic                   out_valid_q, out_found_q;
  logic [OFFSET_BITS-1:0] out_offset_q;

  logic                   in_xfer, advance, clear, take;
  logic                   new_latched;
  logic [OFFSET_BITS-1:0] new_first;

  assign cfg_ready_o = 1'b1;

  wbps_cfg_regs #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // pipeline control: only a last byte can be held by a waiting result
  assign advance    = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign clear      = advance && s1_last_q;

  wbps_window #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
    .OFFSET_BITS      (OFFSET_BITS)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_i    (in_xfer),
    .clear_i    (clear),
    .data_byte_i(data_byte_i),
    .window_o   (window),
    .count_o    (count)
  );

  wbps_match #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_match (
    .window_i(window),
    .cfg_i   (cfg),
    .hit_o   (hit)
  );

  // first match latch, offset must fit the result field
  always_comb begin
    start       = count - CNT_W'(cfg.length);
    take        = s1_valid_q && !latched_q && hit &&
                  (count >= CNT_W'(cfg.length)) && !start[OFFSET_BITS];
    new_latched = latched_q || take;
    new_first   = take ? start[OFFSET_BITS-1:0] : first_q;
  end

  // compare stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
        s1_last_q  <= last_byte_i;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // per-image match state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q <= 1'b0;
      first_q   <= '0;
    end else if (advance) begin
      if (s1_last_q) begin
        latched_q <= 1'b0;
        first_q   <= '0;
      end else begin
        latched_q <= new_latched;
        first_q   <= new_first;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (clear) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear) begin
      out_found_q  <= new_latched;
      out_offset_q <= new_latched ? new_first : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign match_offset_o = out_offset_q;

  // checks
  a_clear_resets_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> !latched_q)
    else $error("match latch not cleared after end of image");

  a_take_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && advance && !s1_last_q) |=> (latched_q && first_q == $past(start[OFFSET_BITS-1:0])))
    else $error("first match not latched");

  a_no_hit_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (match_offset_o == '0))
    else $error("offset not zero on a miss");

  a_mid_image_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_last_q) |-> in_ready_o)
    else $error("non-final byte stalled the input");

endmodule

// File: rtl/wbps_cfg_regs.sv
// ----------------------------------------------------------------------------
// wbps_cfg_regs
// Pattern and length registers, with the length clamped to the usable range.
// ----------------------------------------------------------------------------
module wbps_cfg_regs #(
  parameter int unsigned MAX_PATTERN_BYTES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output wbps_pkg::cfg_t                      cfg_o
);
  import wbps_pkg::*;

  logic [CFG_DATA_W-1:0] pat_low_q;
  logic [CFG_DATA_W-1:0] pat_high_q;
  logic [PAT_LEN_W-1:0]  pat_len_q;
  cfg_reg_e              idx;

  assign idx = cfg_reg_e'(cfg_index_i);

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= PAT_LEN_W'(1);
    end else if (cfg_valid_i) begin
      unique case (idx)
        CFG_PATTERN_LOW:    pat_low_q  <= cfg_data_i;
        CFG_PATTERN_HIGH:   pat_high_q <= cfg_data_i;
        CFG_PATTERN_LENGTH: pat_len_q  <= cfg_data_i[PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // byte view of the pattern and clamped length
  always_comb begin
    cfg_o.pattern = pattern_t'({pat_high_q, pat_low_q});
    if (pat_len_q == '0) begin
      cfg_o.length = PAT_LEN_W'(1);
    end else if (pat_len_q > PAT_LEN_W'(MAX_PATTERN_BYTES)) begin
      cfg_o.length = PAT_LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      cfg_o.length = pat_len_q;
    end
  end

endmodule

// File: rtl/wbps_window.sv
// ----------------------------------------------------------------------------
// wbps_window
// Shift window of the latest image bytes and the saturating byte count.
// ----------------------------------------------------------------------------
module wbps_window #(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned OFFSET_BITS       = 20
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  shift_i,
  input  logic                                  clear_i,
  input  logic [7:0]                            data_byte_i,
  output logic [MAX_PATTERN_BYTES-1:0][7:0]     window_o,
  output logic [OFFSET_BITS:0]                  count_o
);
  import wbps_pkg::*;

  localparam logic [OFFSET_BITS:0] COUNT_MAX = '1;

  logic [MAX_PATTERN_BYTES-1:0][7:0] window_q, window_d, window_base;
  logic [OFFSET_BITS:0]              count_q, count_d, count_base;

  // a clear of the finished image and the first byte of the next may meet
  always_comb begin
    window_base = clear_i ? '0 : window_q;
    count_base  = clear_i ? '0 : count_q;
    window_d    = window_base;
    count_d     = count_base;
    if (shift_i) begin
      window_d[0] = data_byte_i;
      for (int k = 1; k < int'(MAX_PATTERN_BYTES); k++) begin
        window_d[k] = window_base[k-1];
      end
      if (count_base != COUNT_MAX) begin
        count_d = count_base + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      count_q  <= '0;
    end else begin
      window_q <= window_d;
      count_q  <= count_d;
    end
  end

  assign window_o = window_q;
  assign count_o  = count_q;

endmodule

// File: rtl/wbps_match.sv
// ----------------------------------------------------------------------------
// wbps_match
// Parallel wildcard compare of the pattern against the newest window bytes.
// ----------------------------------------------------------------------------
module wbps_match #(
  parameter int unsigned MAX_PATTERN_BYTES = 16
) (
  input  logic [MAX_PATTERN_BYTES-1:0][7:0] window_i,
  input  wbps_pkg::cfg_t                    cfg_i,
  output logic                              hit_o
);
  import wbps_pkg::*;

  logic [MAX_PATTERN_BYTES-1:0] lane_ok;

  // window entry k (newest first) lines up with pattern byte length-1-k
  always_comb begin
    for (int k = 0; k < int'(MAX_PATTERN_BYTES); k++) begin
      logic [PAT_LEN_W-1:0] pidx;
      logic [7:0]           pbyte;
      pidx       = cfg_i.length - PAT_LEN_W'(1) - PAT_LEN_W'(k);
      pbyte      = cfg_i.pattern[pidx[PAT_IDX_W-1:0]];
      lane_ok[k] = (PAT_LEN_W'(k) >= cfg_i.length) || (pbyte == WILDCARD) ||
                   (pbyte == window_i[k]);
    end
  end

  assign hit_o = &lane_ok;

endmodule

// File: verif/tb_wildcard_byte_pattern_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wildcard_byte_pattern_search
// Self-checking bench for the wildcard byte pattern search block. Images are
// streamed byte by byte, mostly under random back-pressure on both sides. Each
// result is compared with a cycle-free model of the search that is updated on
// every accepted byte and every register write.
// ----------------------------------------------------------------------------
module tb_wildcard_byte_pattern_search;
  import wbps_pkg::*;

  localparam int unsigned OFFSET_BITS   = 20;
  localparam int unsigned MAX_BYTES     = 16;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned PHASE_BYTES   = 400;

  typedef struct packed {
    logic                   found;
    logic [OFFSET_BITS-1:0] offset;
  } search_result_t;

  // search model and queue of results still to arrive
  class search_scoreboard;
    pattern_t               pattern;
    logic [PAT_LEN_W-1:0]   length;
    logic [7:0]             window [MAX_BYTES];
    logic [OFFSET_BITS:0]   seen;
    logic                   latched;
    logic [OFFSET_BITS-1:0] first_offset;
    search_result_t         expected_results [$];
    int unsigned            errors;

    function new();
      pattern = '0;
      length  = PAT_LEN_W'(1);
      errors  = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (window[i]) window[i] = 8'h00;
      seen         = '0;
      latched      = 1'b0;
      first_offset = '0;
    endfunction

    // zero counts as one, anything above the window as the full window
    function int unsigned effective_length(logic [PAT_LEN_W-1:0] n);
      if (n == 0) return 1;
      if (n > MAX_BYTES) return MAX_BYTES;
      return n;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_PATTERN_LOW:    pattern[7:0]  = value;
        CFG_PATTERN_HIGH:   pattern[15:8] = value;
        CFG_PATTERN_LENGTH: length        = value[PAT_LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted byte: shift, compare, and on the last byte queue a result
    function void note_byte(logic [7:0] data, logic last);
      int unsigned          used;
      logic                 hit;
      logic [OFFSET_BITS:0] start;
      search_result_t       res;
      used = effective_length(length);
      for (int i = MAX_BYTES - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = data;
      if (seen != '1) seen++;
      if (!latched && seen >= used) begin
        start = seen - used;
        hit   = 1'b1;
        for (int i = 0; i < used; i++) begin
          if (pattern[i] != WILDCARD && pattern[i] != window[used-1-i]) hit = 1'b0;
        end
        // a start beyond the offset range is never latched
        if (hit && !start[OFFSET_BITS]) begin
          latched      = 1'b1;
          first_offset = start[OFFSET_BITS-1:0];
        end
      end
      if (last) begin
        res.found  = latched;
        res.offset = latched ? first_offset : '0;
        expected_results.push_back(res);
        clear_stream();
      end
    endfunction

    function void check_result(logic found, logic [OFFSET_BITS-1:0] offset);
      search_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, actual found=%0b offset=%0d",
                 $time, found, offset);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (found !== want.found) begin
        $display("%0t: found mismatch, expected %0b actual %0b",
                 $time, want.found, found);
        errors++;
      end
      if (offset !== want.offset) begin
        $display("%0t: match_offset mismatch, expected %0d actual %0d",
                 $time, want.offset, offset);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [7:0]             data_byte_i;
  logic                   last_byte_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   found_o;
  logic [OFFSET_BITS-1:0] match_offset_o;

  search_scoreboard sb;
  int unsigned      snd_idle;
  int unsigned      rcv_idle;
  pattern_t         stim_pattern;
  int unsigned      stim_len;

  wildcard_byte_pattern_search #(
    .MAX_PATTERN_BYTES (MAX_BYTES),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .match_offset_o (match_offset_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result side back-pressure
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(99) >= rcv_idle);
    end
  end

  // result transfers go to the scoreboard
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_result(found_o, match_offset_o);
    end
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // one byte transfer, entered and left at a falling edge
  task automatic send_byte(input logic [7:0] data, input logic last);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    data_byte_i = data;
    last_byte_i = last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(data, last);
    @(negedge clk_i);
  endtask

  // hold the byte stream until every result is in and the pipe is empty
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, value);
    @(negedge clk_i);
  endtask

  task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [63:0] len_word);
    drain();
    write_reg(CFG_PATTERN_LOW, lo);
    write_reg(CFG_PATTERN_HIGH, hi);
    write_reg(CFG_PATTERN_LENGTH, len_word);
    cfg_valid_i  = 1'b0;
    stim_pattern = {hi, lo};
    stim_len     = sb.effective_length(len_word[PAT_LEN_W-1:0]);
  endtask

  // byte from a three-symbol alphabet so that partial matches are common
  function automatic logic [7:0] alpha_byte();
    return 8'h5C + 8'($urandom_range(2));
  endfunction

  task automatic random_pattern();
    pattern_t      pat;
    logic [63:0]   len_word;
    int unsigned   r;
    r = $urandom_range(99);
    if (r < 5) len_word[PAT_LEN_W-1:0] = '0;
    else if (r < 10) len_word[PAT_LEN_W-1:0] = 5'($urandom_range(31, 17));
    else if (r < 22) len_word[PAT_LEN_W-1:0] = 5'd16;
    else len_word[PAT_LEN_W-1:0] = 5'($urandom_range(16, 1));
    len_word[63:PAT_LEN_W] = {$urandom, 27'($urandom)};
    for (int i = 0; i < MAX_BYTES; i++) begin
      r = $urandom_range(99);
      if (r < 30) pat[i] = WILDCARD;
      else if (r < 75) pat[i] = alpha_byte();
      else pat[i] = 8'($urandom_range(255));
    end
    r = $urandom_range(99);
    if (r < 3) pat = '1;
    else if (r < 6) pat = '0;
    load_pattern(pat[7:0], pat[15:8], len_word);
  endtask

  // mostly images with the pattern planted, the rest noise
  task automatic build_image(output logic [7:0] img[$]);
    int unsigned size;
    int unsigned mode;
    int unsigned pos;
    img  = {};
    size = ($urandom_range(99) < 85) ? $urandom_range(24, 1) : $urandom_range(64, 25);
    mode = $urandom_range(99);
    if (mode < 55 && size < stim_len) size = stim_len + $urandom_range(8);
    for (int k = 0; k < size; k++) begin
      if (mode < 80 && $urandom_range(3) != 0) img.push_back(alpha_byte());
      else img.push_back(8'($urandom_range(255)));
    end
    if (mode < 55) begin
      pos = $urandom_range(size - stim_len);
      for (int k = 0; k < stim_len; k++) begin
        if (stim_pattern[k] != WILDCARD) img[pos+k] = stim_pattern[k];
      end
    end
  endtask

  task automatic send_image(input logic [7:0] img[$], input bit mid_cfg);
    for (int k = 0; k < img.size(); k++) begin
      // register change part-way through an image
      if (mid_cfg && k == img.size() / 2) random_pattern();
      send_byte(img[k], k == img.size() - 1);
    end
  endtask

  // main sequence
  initial begin : main
    logic [7:0]  img [$];
    logic [7:0]  ones [$];
    int unsigned sent;
    sb          = new();
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_PATTERN_LOW;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    last_byte_i = 1'b0;
    snd_idle    = 33;
    rcv_idle    = 47;
    stim_pattern = '0;
    stim_len     = 1;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset pattern is a single wildcard: every one-byte image matches
    img = '{8'hFF};
    send_image(img, 1'b0);
    img = '{8'h00};
    send_image(img, 1'b0);

    // wildcard in the middle, and an image shorter than the pattern
    load_pattern(64'h55_00_AA, 64'h0, 64'd3);
    img = '{8'h11, 8'hAA, 8'h77, 8'h55};
    send_image(img, 1'b0);
    img = '{8'hAA, 8'h55};
    send_image(img, 1'b0);

    // length zero behaves as one
    load_pattern(64'hFF, 64'h0, 64'd0);
    img = '{8'h00, 8'hFF};
    send_image(img, 1'b0);

    // oversized length clamps to the full window, all pattern bits set
    load_pattern('1, '1, 64'd31);
    for (int k = 0; k < MAX_BYTES; k++) ones.push_back(8'hFF);
    send_image(ones, 1'b0);

    // random images in three back-pressure phases, the last one with none
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        snd_idle = 47;
        rcv_idle = 33;
      end else if (phase == 2) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      random_pattern();
      sent = 0;
      while (sent < PHASE_BYTES) begin
        if ($urandom_range(9) == 0) random_pattern();
        build_image(img);
        send_image(img, img.size() > 1 && $urandom_range(19) == 0);
        sent += img.size();
      end
    end

    // wait for the last results, then a few quiet cycles for strays
    in_valid_i = 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
